// ===== src/dfos_pkg.sv =====
`default_nettype none

package dfos_pkg;

  // Field widths
  localparam int DIST_W   = 10;
  localparam int SMOOTH_W = 18;
  localparam int GAIN_W   = 9;
  localparam int DELAY_W  = 16;
  localparam int LIMIT_W  = 8;
  localparam int FRAC_W   = 8;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 3;

  typedef logic [DIST_W-1:0]   dist_t;
  typedef logic [SMOOTH_W-1:0] smooth_t;
  typedef logic [GAIN_W-1:0]   gain_t;
  typedef logic [DELAY_W-1:0]  delay_t;
  typedef logic [LIMIT_W-1:0]  limit_t;
  typedef logic [1:0]          drv_event_t;

  // Drive event codes
  localparam drv_event_t EV_NONE  = 2'd0;
  localparam drv_event_t EV_START = 2'd1;
  localparam drv_event_t EV_STOP  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WALL_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_DELAY     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_GAIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_GAIN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHANGE_LIMIT   = 3'd4;

  // Configuration reset values
  localparam dist_t  WALL_THRESHOLD_RST = 10'd30;
  localparam delay_t STOP_DELAY_RST     = 16'd1300;
  localparam gain_t  FAST_GAIN_RST      = 9'd179;
  localparam gain_t  SLOW_GAIN_RST      = 9'd26;
  localparam limit_t CHANGE_LIMIT_RST   = 8'd1;

  // Unity gain in Q1.8
  localparam gain_t GAIN_ONE = 9'd256;

  // Status handed from the stop logic to the result register
  typedef struct packed {
    logic       obstacle_seen;
    logic       drive_enable;
    drv_event_t drive_event;
  } stop_status_t;

endpackage

`default_nettype wire

// ===== src/dfos_in_if.sv =====
`default_nettype none

interface dfos_in_if import dfos_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  sample_valid;
  dist_t distance_cm;

  modport source (output valid, output sample_valid, output distance_cm, input ready);
  modport sink (input valid, input sample_valid, input distance_cm, output ready);
endinterface

`default_nettype wire

// ===== src/dfos_out_if.sv =====
`default_nettype none

interface dfos_out_if import dfos_pkg::*; ();
  logic       valid;
  logic       ready;
  smooth_t    filtered_distance;
  dist_t      median_distance;
  logic       obstacle_seen;
  logic       drive_enable;
  drv_event_t drive_event;

  modport source (
    output valid, output filtered_distance, output median_distance,
    output obstacle_seen, output drive_enable, output drive_event, input ready
  );
  modport sink (
    input valid, input filtered_distance, input median_distance,
    input obstacle_seen, input drive_enable, input drive_event, output ready
  );
endinterface

`default_nettype wire

// ===== src/dfos_window.sv =====
`default_nettype none

module dfos_window import dfos_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  en,
  input  wire logic  sample_valid,
  input  wire dist_t distance_cm,
  output dist_t      median
);

  dist_t      win [3];
  dist_t      win_next [3];
  logic [1:0] index;
  logic [1:0] index_next;
  logic [1:0] wr_idx;

  function automatic dist_t median3(input dist_t a, input dist_t b, input dist_t c);
    dist_t m;
    if (a <= b && a <= c) begin
      m = (b <= c) ? b : c;
    end else if (b <= a && b <= c) begin
      m = (a <= c) ? a : c;
    end else begin
      m = (a <= b) ? a : b;
    end
    return m;
  endfunction

  // Write the new sample into its slot and take the median of the result
  always_comb begin
    wr_idx = (index == 2'd3) ? 2'd0 : index;
    for (int i = 0; i < 3; i++) begin
      win_next[i] = (sample_valid && wr_idx == 2'(i)) ? distance_cm : win[i];
    end
    if (sample_valid) begin
      index_next = (wr_idx == 2'd2) ? 2'd0 : wr_idx + 2'd1;
    end else begin
      index_next = index;
    end
    median = median3(win_next[0], win_next[1], win_next[2]);
  end

  // Advance the window on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) win[i] <= '0;
      index <= 2'd0;
    end else if (en) begin
      for (int i = 0; i < 3; i++) win[i] <= win_next[i];
      index <= index_next;
    end
  end

  ap_index_range: assert property (@(posedge clk) disable iff (rst) index != 2'd3)
    else $error("window index out of range");
  ap_index_hold: assert property (@(posedge clk) disable iff (rst) !en |=> $stable(index))
    else $error("window index moved without a transfer");
  ap_index_step: assert property (@(posedge clk) disable iff (rst)
    en && !sample_valid |=> $stable(index))
    else $error("window index moved on a tick without a sample");

endmodule

`default_nettype wire

// ===== src/dfos_smoother.sv =====
`default_nettype none

module dfos_smoother import dfos_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   en,
  input  wire logic   sample_valid,
  input  wire dist_t  median,
  input  wire gain_t  fast_gain,
  input  wire gain_t  slow_gain,
  input  wire limit_t change_limit,
  output smooth_t     smooth_next
);

  smooth_t       smooth;
  smooth_t       med_q;
  smooth_t       diff;
  gain_t         gain_sel;
  gain_t         gain_sat;
  gain_t         gain_inv;
  logic [18:0]   med_prod;
  logic [25:0]   old_prod;
  logic [27:0]   sum;

  // Pick the gain from the size of the change and blend median with history
  always_comb begin
    med_q    = {median, {FRAC_W{1'b0}}};
    diff     = (smooth >= med_q) ? smooth - med_q : med_q - smooth;
    gain_sel = (diff[SMOOTH_W-1:FRAC_W] > {2'b00, change_limit}) ? fast_gain : slow_gain;
    gain_sat = (gain_sel > GAIN_ONE) ? GAIN_ONE : gain_sel;
    gain_inv = GAIN_ONE - gain_sat;
    med_prod = {9'd0, median} * {10'd0, gain_sat};
    old_prod = {8'd0, smooth} * {17'd0, gain_inv};
    sum      = {1'b0, med_prod, 8'd0} + {2'b00, old_prod} + 28'd128;
    smooth_next = sample_valid ? sum[25:8] : smooth;
  end

  // Hold the smoothed value between transfers
  always_ff @(posedge clk) begin
    if (rst) begin
      smooth <= '0;
    end else if (en) begin
      smooth <= smooth_next;
    end
  end

  ap_hold: assert property (@(posedge clk) disable iff (rst)
    en && !sample_valid |=> $stable(smooth))
    else $error("smoothed value moved on a tick without a sample");
  ap_bound: assert property (@(posedge clk) disable iff (rst)
    en && sample_valid && smooth <= med_q |-> smooth_next <= med_q)
    else $error("smoothed value overshot the median");
  ap_bound_dn: assert property (@(posedge clk) disable iff (rst)
    en && sample_valid && smooth >= med_q |-> smooth_next >= med_q)
    else $error("smoothed value undershot the median");

endmodule

`default_nettype wire

// ===== src/dfos_stop.sv =====
`default_nettype none

module dfos_stop import dfos_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    en,
  input  wire smooth_t smooth_next,
  input  wire dist_t   wall_threshold,
  input  wire delay_t  stop_delay_ms,
  output stop_status_t status
);

  logic   obstacle;
  logic   stopped;
  delay_t dwell;
  logic   obstacle_next;
  logic   stopped_next;
  delay_t dwell_next;
  logic   below;

  // Track how long the obstacle persists and decide on stop and restart
  always_comb begin
    obstacle_next      = obstacle;
    stopped_next       = stopped;
    dwell_next         = dwell;
    status.drive_event = EV_NONE;
    below = smooth_next < {wall_threshold, {FRAC_W{1'b0}}};
    if (below) begin
      if (!obstacle) begin
        obstacle_next = 1'b1;
        dwell_next    = '0;
      end else if (dwell != '1) begin
        dwell_next = dwell + 1'b1;
      end
    end else begin
      obstacle_next = 1'b0;
      if (stopped) begin
        stopped_next       = 1'b0;
        status.drive_event = EV_START;
      end
    end
    if (obstacle_next && dwell_next > stop_delay_ms && !stopped_next) begin
      stopped_next       = 1'b1;
      status.drive_event = EV_STOP;
    end
    status.obstacle_seen = obstacle_next;
    status.drive_enable  = !stopped_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      obstacle <= 1'b0;
      stopped  <= 1'b1;
      dwell    <= '0;
    end else if (en) begin
      obstacle <= obstacle_next;
      stopped  <= stopped_next;
      dwell    <= dwell_next;
    end
  end

  ap_stop_event: assert property (@(posedge clk) disable iff (rst)
    en && status.drive_event == EV_STOP |=> stopped && obstacle)
    else $error("stop event without the drive held stopped");
  ap_start_only_stopped: assert property (@(posedge clk) disable iff (rst)
    en && status.drive_event == EV_START |-> stopped)
    else $error("start event while the drive already ran");
  ap_no_change_idle: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(stopped) && $stable(dwell))
    else $error("stop state moved without a transfer");

endmodule

`default_nettype wire

// ===== src/distance_filter_obstacle_stop.sv =====
// Channel  Direction  Payload
// in_ch    sink       sample_valid, distance_cm
// out_ch   source     filtered_distance, median_distance, obstacle_seen,
//                     drive_enable, drive_event
// cfg      write      cfg_we, cfg_index, cfg_data (no read-back)
//
// One tick per cycle sustained while out_ch.ready stays high; a tick goes
// from the input register through one pass of median, blend and compare
// into the result register, which loads when empty or being drained.
// A stalled result holds, and the input register still
// takes one more tick; in_ch.ready drops only when both are full.
// rst is synchronous: window, smoother and counters clear, drive stopped.
`default_nettype none

module distance_filter_obstacle_stop import dfos_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  dfos_in_if.sink                   in_ch,
  dfos_out_if.source                out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  dist_t        wall_threshold;
  delay_t       stop_delay_ms;
  gain_t        fast_gain;
  gain_t        slow_gain;
  limit_t       change_limit;

  logic         s1_valid;
  logic         s1_sample_valid;
  dist_t        s1_distance;
  logic         advance;

  dist_t        median;
  smooth_t      smooth_next;
  stop_status_t status;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      wall_threshold <= WALL_THRESHOLD_RST;
      stop_delay_ms  <= STOP_DELAY_RST;
      fast_gain      <= FAST_GAIN_RST;
      slow_gain      <= SLOW_GAIN_RST;
      change_limit   <= CHANGE_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WALL_THRESHOLD: wall_threshold <= cfg_data[DIST_W-1:0];
        REG_STOP_DELAY:     stop_delay_ms  <= cfg_data[DELAY_W-1:0];
        REG_FAST_GAIN:      fast_gain      <= cfg_data[GAIN_W-1:0];
        REG_SLOW_GAIN:      slow_gain      <= cfg_data[GAIN_W-1:0];
        REG_CHANGE_LIMIT:   change_limit   <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance a held tick when the result register is empty or being drained
  assign advance     = s1_valid && (!out_ch.valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_sample_valid <= in_ch.sample_valid;
      s1_distance     <= in_ch.distance_cm;
    end
  end

  dfos_window u_window (
    .clk          (clk),
    .rst          (rst),
    .en           (advance),
    .sample_valid (s1_sample_valid),
    .distance_cm  (s1_distance),
    .median       (median)
  );

  dfos_smoother u_smoother (
    .clk          (clk),
    .rst          (rst),
    .en           (advance),
    .sample_valid (s1_sample_valid),
    .median       (median),
    .fast_gain    (fast_gain),
    .slow_gain    (slow_gain),
    .change_limit (change_limit),
    .smooth_next  (smooth_next)
  );

  dfos_stop u_stop (
    .clk            (clk),
    .rst            (rst),
    .en             (advance),
    .smooth_next    (smooth_next),
    .wall_threshold (wall_threshold),
    .stop_delay_ms  (stop_delay_ms),
    .status         (status)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (advance) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ch.filtered_distance <= smooth_next;
      out_ch.median_distance   <= median;
      out_ch.obstacle_seen     <= status.obstacle_seen;
      out_ch.drive_enable      <= status.drive_enable;
      out_ch.drive_event       <= status.drive_event;
    end
  end

  ap_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ch.ready)
    else $error("input refused with the input register empty");
  ap_advance_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_ch.valid)
    else $error("result lost after an advance");
  ap_stop_flags: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.drive_event == EV_STOP |-> !out_ch.drive_enable && out_ch.obstacle_seen)
    else $error("stop event with inconsistent flags");
  ap_start_flags: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.drive_event == EV_START |-> out_ch.drive_enable && !out_ch.obstacle_seen)
    else $error("start event with inconsistent flags");

endmodule

`default_nettype wire

// ===== sim/tb_distance_filter_obstacle_stop.sv =====
`timescale 1ns / 100ps

module tb_distance_filter_obstacle_stop;
  import dfos_pkg::*;

  typedef struct packed {
    smooth_t    filtered_distance;
    dist_t      median_distance;
    logic       obstacle_seen;
    logic       drive_enable;
    drv_event_t drive_event;
  } filter_result_t;

  // One directed tick; the result is typed in only where it is plain to see
  typedef struct packed {
    logic           sample_valid;
    dist_t          distance_cm;
    logic           typed;
    filter_result_t result;
  } tick_row_t;

  // Register setting and handshake pressure for one random phase
  typedef struct {
    int wall;
    int delay;
    int fast;
    int slow;
    int limit;
    int src_idle;
    int snk_idle;
    int ticks;
  } setting_t;

  localparam int NUM_ROWS = 22;
  localparam int NUM_SETTINGS = 6;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  dfos_in_if  in_ch ();
  dfos_out_if out_ch ();

  distance_filter_obstacle_stop DUT (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Filter state as the block should hold it
  dist_t     win_q [3];
  logic [1:0] win_ptr;
  smooth_t   smooth_q;
  logic      obstacle_q;
  logic      stopped_q;
  delay_t    dwell_q;

  // Register copies
  dist_t  wall_cfg;
  delay_t delay_cfg;
  gain_t  fast_cfg;
  gain_t  slow_cfg;
  limit_t limit_cfg;

  filter_result_t pending_results [$];

  // Typed result handed from the driver along with the payload
  logic           row_typed;
  filter_result_t row_result;

  int src_idle;
  int snk_idle;
  int errors;
  int ticks_sent;
  int results_checked;
  int starts_seen;
  int stops_seen;

  tick_row_t directed_rows [NUM_ROWS] = '{
    '{1'b0, 10'd0,    1'b1, '{18'd0, 10'd0, 1'b1, 1'b0, EV_NONE}},
    '{1'b0, 10'd1023, 1'b1, '{18'd0, 10'd0, 1'b1, 1'b0, EV_NONE}},
    '{1'b1, 10'd1023, 1'b1, '{18'd0, 10'd0, 1'b1, 1'b0, EV_NONE}},
    '{1'b1, 10'd1023, 1'b0, '0},
    '{1'b1, 10'd1023, 1'b0, '0},
    '{1'b1, 10'd0,    1'b0, '0},
    '{1'b1, 10'd0,    1'b0, '0},
    '{1'b0, 10'd512,  1'b0, '0},
    '{1'b1, 10'd0,    1'b0, '0},
    '{1'b1, 10'd30,   1'b0, '0},
    '{1'b1, 10'd30,   1'b0, '0},
    '{1'b1, 10'd30,   1'b0, '0},
    '{1'b1, 10'd29,   1'b0, '0},
    '{1'b1, 10'd31,   1'b0, '0},
    '{1'b1, 10'd29,   1'b0, '0},
    '{1'b0, 10'd0,    1'b0, '0},
    '{1'b1, 10'd512,  1'b0, '0},
    '{1'b1, 10'd1,    1'b0, '0},
    '{1'b1, 10'd1022, 1'b0, '0},
    '{1'b1, 10'd682,  1'b0, '0},
    '{1'b1, 10'd341,  1'b0, '0},
    '{1'b1, 10'd1023, 1'b0, '0}
  };

  setting_t settings [NUM_SETTINGS] = '{
    '{30,   3,     179, 26,  1,   11, 58, 90},
    '{1023, 0,     511, 511, 255, 11, 58, 60},
    '{0,    65535, 0,   0,   0,   58, 11, 50},
    '{100,  10,    256, 300, 8,   58, 11, 120},
    '{512,  65535, 200, 40,  128, 0,  0,  60},
    '{60,   20,    179, 26,  1,   0,  0,  200}
  };

  // Advance the filter by one tick and return the result it should report
  function automatic filter_result_t advance_filter(logic sample_valid, dist_t distance);
    logic [1:0]  slot;
    dist_t       lo;
    dist_t       hi;
    dist_t       med;
    int unsigned m16;
    int unsigned diff;
    int unsigned gain;
    int unsigned blended;
    drv_event_t  ev;
    ev = EV_NONE;
    if (sample_valid) begin
      slot = (win_ptr > 2'd2) ? 2'd0 : win_ptr;
      win_q[slot] = distance;
      win_ptr = (slot == 2'd2) ? 2'd0 : slot + 2'd1;
    end
    lo = (win_q[0] < win_q[1]) ? win_q[0] : win_q[1];
    hi = (win_q[0] < win_q[1]) ? win_q[1] : win_q[0];
    med = (win_q[2] < lo) ? lo : ((win_q[2] > hi) ? hi : win_q[2]);
    // Blend the median in, fast gain on a large jump, gain capped at one
    if (sample_valid) begin
      m16 = int'(med) << FRAC_W;
      diff = (smooth_q >= m16) ? smooth_q - m16 : m16 - smooth_q;
      gain = ((diff >> FRAC_W) > limit_cfg) ? 32'(fast_cfg) : 32'(slow_cfg);
      if (gain > GAIN_ONE)
        gain = 32'(GAIN_ONE);
      blended = (m16 * gain + smooth_q * (GAIN_ONE - gain) + 128) >> FRAC_W;
      smooth_q = smooth_t'(blended);
    end
    // Obstacle dwell and drive start/stop
    if (smooth_q < {wall_cfg, 8'h00}) begin
      if (!obstacle_q) begin
        obstacle_q = 1'b1;
        dwell_q = '0;
      end else if (dwell_q != 16'hFFFF) begin
        dwell_q = dwell_q + 16'd1;
      end
    end else begin
      obstacle_q = 1'b0;
      if (stopped_q) begin
        stopped_q = 1'b0;
        ev = EV_START;
      end
    end
    if (obstacle_q && dwell_q > delay_cfg && !stopped_q) begin
      stopped_q = 1'b1;
      ev = EV_STOP;
    end
    return '{smooth_q, med, obstacle_q, !stopped_q, ev};
  endfunction

  // Offer one tick, with random idle cycles ahead of it, and hold until transfer
  task automatic send_tick(logic sample_valid, dist_t distance, logic typed,
                           filter_result_t result);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.sample_valid = sample_valid;
    in_ch.distance_cm = distance;
    row_typed = typed;
    row_result = result;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = CFG_W'(value);
    case (idx)
      REG_WALL_THRESHOLD: wall_cfg = dist_t'(value);
      REG_STOP_DELAY:     delay_cfg = delay_t'(value);
      REG_FAST_GAIN:      fast_cfg = gain_t'(value);
      REG_SLOW_GAIN:      slow_cfg = gain_t'(value);
      REG_CHANGE_LIMIT:   limit_cfg = limit_t'(value);
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Stop offering ticks and let every outstanding result arrive
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_ch.ready <= !rst && ($urandom_range(0, 99) >= snk_idle);
  end

  // Check each result transfer, then predict for each tick transfer
  always @(posedge clk) begin : monitor
    filter_result_t want;
    filter_result_t got;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.filtered_distance, out_ch.median_distance, out_ch.obstacle_seen,
                out_ch.drive_enable, out_ch.drive_event};
        if (got.drive_event == EV_START)
          starts_seen++;
        if (got.drive_event == EV_STOP)
          stops_seen++;
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing expected");
          errors++;
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (got.filtered_distance !== want.filtered_distance) begin
            $error("filtered_distance: expected %0d, got %0d",
                   want.filtered_distance, got.filtered_distance);
            errors++;
          end
          if (got.median_distance !== want.median_distance) begin
            $error("median_distance: expected %0d, got %0d",
                   want.median_distance, got.median_distance);
            errors++;
          end
          if (got.obstacle_seen !== want.obstacle_seen) begin
            $error("obstacle_seen: expected %0d, got %0d",
                   want.obstacle_seen, got.obstacle_seen);
            errors++;
          end
          if (got.drive_enable !== want.drive_enable) begin
            $error("drive_enable: expected %0d, got %0d",
                   want.drive_enable, got.drive_enable);
            errors++;
          end
          if (got.drive_event !== want.drive_event) begin
            $error("drive_event: expected %0d, got %0d",
                   want.drive_event, got.drive_event);
            errors++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        want = advance_filter(in_ch.sample_valid, in_ch.distance_cm);
        pending_results.push_back(row_typed ? row_result : want);
        ticks_sent++;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("distance_filter_obstacle_stop verification failed");
    $finish;
  end

  initial begin : stimulus
    int k;
    int p;
    int sent;
    int level;
    int seg_len;
    int wall;
    logic sample_valid;
    dist_t distance;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.sample_valid = 1'b0;
    in_ch.distance_cm = '0;
    out_ch.ready = 1'b0;
    row_typed = 1'b0;
    row_result = '0;
    errors = 0;
    ticks_sent = 0;
    results_checked = 0;
    starts_seen = 0;
    stops_seen = 0;
    src_idle = 11;
    snk_idle = 58;

    // Filter state and registers as they come out of reset
    for (k = 0; k < 3; k++)
      win_q[k] = '0;
    win_ptr = '0;
    smooth_q = '0;
    obstacle_q = 1'b0;
    stopped_q = 1'b1;
    dwell_q = '0;
    wall_cfg = WALL_THRESHOLD_RST;
    delay_cfg = STOP_DELAY_RST;
    fast_cfg = FAST_GAIN_RST;
    slow_cfg = SLOW_GAIN_RST;
    limit_cfg = CHANGE_LIMIT_RST;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed ticks under the reset register values
    for (k = 0; k < NUM_ROWS; k++)
      send_tick(directed_rows[k].sample_valid, directed_rows[k].distance_cm,
                directed_rows[k].typed, directed_rows[k].result);

    // Random phases, one register setting each
    for (p = 0; p < NUM_SETTINGS; p++) begin
      drain();
      write_reg(REG_WALL_THRESHOLD, settings[p].wall);
      write_reg(REG_STOP_DELAY, settings[p].delay);
      write_reg(REG_FAST_GAIN, settings[p].fast);
      write_reg(REG_SLOW_GAIN, settings[p].slow);
      write_reg(REG_CHANGE_LIMIT, settings[p].limit);
      src_idle = settings[p].src_idle;
      snk_idle = settings[p].snk_idle;
      wall = settings[p].wall;
      sent = 0;
      // Runs below, above, near the wall, random or extreme so the drive cycles
      while (sent < settings[p].ticks) begin
        level = $urandom_range(0, 4);
        seg_len = $urandom_range(3, 40);
        repeat (seg_len) begin
          if (level == 4)
            sample_valid = 1'($urandom_range(0, 1));
          else
            sample_valid = ($urandom_range(0, 99) < 85);
          case (level)
            0: distance = (wall == 0) ? 10'd0 : dist_t'($urandom_range(0, wall - 1));
            1: distance = dist_t'($urandom_range(wall, 1023));
            2: distance = dist_t'($urandom_range((wall < 3) ? 0 : wall - 3,
                                                 (wall > 1020) ? 1023 : wall + 3));
            3: distance = dist_t'($urandom_range(0, 1023));
            default: distance = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
          endcase
          send_tick(sample_valid, distance, 1'b0, '0);
          sent++;
        end
      end
    end

    drain();
    $display("Ran %0d ticks over %0d register settings, %0d results checked,",
             ticks_sent, NUM_SETTINGS + 1, results_checked);
    $display("with %0d drive starts and %0d drive stops seen.", starts_seen, stops_seen);
    if (errors == 0)
      $display("distance_filter_obstacle_stop verification clean");
    else
      $display("distance_filter_obstacle_stop verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
src/dfos_pkg.sv
src/dfos_in_if.sv
src/dfos_out_if.sv
src/dfos_window.sv
src/dfos_smoother.sv
src/dfos_stop.sv
src/distance_filter_obstacle_stop.sv
sim/tb_distance_filter_obstacle_stop.sv
